// File: src/drma_pkg.sv
// shared widths, types and the reset constant for the dual range moving average unit
`timescale 1ns / 1ps
`default_nettype none

package drma_pkg;

  localparam int unsigned RANGE_W  = 16;
  localparam int unsigned SAMPLE_W = 13;
  localparam int unsigned DIFF_W   = 14;

  typedef logic [RANGE_W-1:0]         range_t;
  typedef logic [SAMPLE_W-1:0]        sample_t;
  typedef logic signed [DIFF_W-1:0]   diff_t;

  localparam sample_t MAX_DIST_RST = SAMPLE_W'(2000);

endpackage

`default_nettype wire

// File: src/drma_if.sv
// valid/ready channels for the sample pair beat and the result beat
`timescale 1ns / 1ps
`default_nettype none

interface drma_in_if import drma_pkg::*; ();
  logic   valid;
  logic   ready;
  range_t left_range;
  logic   left_timed_out;
  range_t right_range;
  logic   right_timed_out;

  modport source (
    output valid, left_range, left_timed_out, right_range, right_timed_out,
    input  ready
  );
  modport sink (
    input  valid, left_range, left_timed_out, right_range, right_timed_out,
    output ready
  );
endinterface

interface drma_out_if import drma_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t left_average;
  sample_t right_average;
  sample_t nearest_distance;
  diff_t   side_difference;

  modport source (
    output valid, left_average, right_average, nearest_distance, side_difference,
    input  ready
  );
  modport sink (
    input  valid, left_average, right_average, nearest_distance, side_difference,
    output ready
  );
endinterface

`default_nettype wire

// File: src/drma_channel.sv
// one sensor channel: clamp, sample window store and exact running sum
`timescale 1ns / 1ps
`default_nettype none

module drma_channel import drma_pkg::*; #(
  parameter int unsigned WINDOW = 8,
  parameter int unsigned SLOT_W = 3,
  parameter int unsigned SUM_W  = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              we_i,
  input  wire logic [SLOT_W-1:0] wr_slot_i,
  input  wire logic [SLOT_W-1:0] rd_slot_i,
  input  wire range_t            range_i,
  input  wire sample_t           limit_i,
  output logic [SUM_W-1:0]       sum_o
);

  sample_t           mem_q [WINDOW];
  sample_t           rd_data_q;
  logic              rd_vld_q;
  logic              byp_q;
  sample_t           byp_data_q;
  logic [WINDOW-1:0] vld_q;
  logic [SUM_W-1:0]  sum_q;
  logic [SUM_W-1:0]  sum_d;
  sample_t           sample;
  sample_t           old_sample;
  logic              same_slot;

  assign sample = (range_i >= {{(RANGE_W-SAMPLE_W){1'b0}}, limit_i}) ?
                  limit_i : range_i[SAMPLE_W-1:0];

  // prefetched entry for the current slot; never-written slots read as zero
  assign old_sample = byp_q    ? byp_data_q :
                      rd_vld_q ? rd_data_q  : '0;

  assign same_slot = we_i && (rd_slot_i == wr_slot_i);

  assign sum_d = sum_q - SUM_W'(old_sample) + SUM_W'(sample);

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_slot_i] <= sample;
    end
    rd_data_q  <= mem_q[rd_slot_i];
    byp_data_q <= sample;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      byp_q    <= 1'b0;
      sum_q    <= '0;
    end else begin
      rd_vld_q <= vld_q[rd_slot_i];
      byp_q    <= same_slot;
      if (we_i) begin
        vld_q[wr_slot_i] <= 1'b1;
        sum_q            <= sum_d;
      end
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

// File: src/drma_avg.sv
// window average by reciprocal multiply, registered
`timescale 1ns / 1ps
`default_nettype none

module drma_avg import drma_pkg::*; #(
  parameter int unsigned WINDOW = 8,
  parameter int unsigned SUM_W  = 16
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [SUM_W-1:0] sum_i,
  output sample_t               avg_o
);

  localparam int unsigned LOG_W  = $clog2(WINDOW);
  localparam int unsigned SHIFT  = SUM_W + LOG_W;
  localparam int unsigned REC_W  = SUM_W + 1;
  localparam int unsigned PROD_W = SUM_W + REC_W;
  // ceil(2^SHIFT / WINDOW) gives an exact floor for every sum below 2^SUM_W
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [REC_W-1:0] REC = REC_W'(RECIP);

  logic [PROD_W-1:0] prod;
  sample_t           avg_q;

  assign prod = PROD_W'(sum_i) * PROD_W'(REC);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      avg_q <= prod[SHIFT +: SAMPLE_W];
    end
  end

  assign avg_o = avg_q;

endmodule

`default_nettype wire

// File: src/dual_range_moving_average_unit.sv
// a result passes the sum, average and result registers in turn after its sample pair beat is accepted
// throughput: one beat per cycle; stages hold and refill under output backpressure
// sample stores update in the accept cycle, averages are taken one stage later
// reset: async active low; windows, sums and slot clear at once, limit returns to 2000
// no clearing pass, entries carry valid bits so the block accepts right after reset
`timescale 1ns / 1ps
`default_nettype none

module dual_range_moving_average_unit import drma_pkg::*; #(
  parameter int unsigned WINDOW = 8
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_we_i,
  input  wire sample_t  cfg_wdata_i,
  drma_in_if.sink       in_i,
  drma_out_if.source    out_o
);

  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W  = SAMPLE_W + $clog2(WINDOW);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  sample_t           max_dist_q;
  logic [SLOT_W-1:0] slot_q;
  logic [SLOT_W-1:0] slot_nxt;
  logic [SLOT_W-1:0] rd_slot;
  logic              accept;
  logic              v1_q;
  logic              v2_q;
  logic              out_vld_q;
  logic              out_free;
  logic              s2_go;
  logic              s2_free;
  logic              s1_go;
  logic [SUM_W-1:0]  left_sum;
  logic [SUM_W-1:0]  right_sum;
  sample_t           left_avg;
  sample_t           right_avg;
  sample_t           left_avg_q;
  sample_t           right_avg_q;
  sample_t           nearest_q;
  diff_t             diff_q;

  // stage chain: sums, then averages, then the result register
  assign out_free  = !out_vld_q || out_o.ready;
  assign s2_go     = v2_q && out_free;
  assign s2_free   = !v2_q || out_free;
  assign s1_go     = v1_q && s2_free;
  assign in_i.ready = !v1_q || s2_free;
  assign accept    = in_i.valid && in_i.ready;

  assign slot_nxt = (slot_q == LAST_SLOT) ? '0 : slot_q + SLOT_W'(1);
  // read port prefetches the slot that the next beat will use
  assign rd_slot  = accept ? slot_nxt : slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= MAX_DIST_RST;
      slot_q     <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_dist_q <= cfg_wdata_i;
      end
      if (accept) begin
        slot_q <= slot_nxt;
      end
      v1_q      <= accept || (v1_q && !s2_free);
      v2_q      <= s1_go || (v2_q && !out_free);
      out_vld_q <= s2_go || (out_vld_q && !out_o.ready);
    end
  end

  drma_channel #(
    .WINDOW (WINDOW),
    .SLOT_W (SLOT_W),
    .SUM_W  (SUM_W)
  ) u_left (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (accept && !in_i.left_timed_out),
    .wr_slot_i (slot_q),
    .rd_slot_i (rd_slot),
    .range_i   (in_i.left_range),
    .limit_i   (max_dist_q),
    .sum_o     (left_sum)
  );

  drma_channel #(
    .WINDOW (WINDOW),
    .SLOT_W (SLOT_W),
    .SUM_W  (SUM_W)
  ) u_right (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (accept && !in_i.right_timed_out),
    .wr_slot_i (slot_q),
    .rd_slot_i (rd_slot),
    .range_i   (in_i.right_range),
    .limit_i   (max_dist_q),
    .sum_o     (right_sum)
  );

  drma_avg #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_left_avg (
    .clk_i (clk_i),
    .en_i  (s1_go),
    .sum_i (left_sum),
    .avg_o (left_avg)
  );

  drma_avg #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_right_avg (
    .clk_i (clk_i),
    .en_i  (s1_go),
    .sum_i (right_sum),
    .avg_o (right_avg)
  );

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      left_avg_q  <= left_avg;
      right_avg_q <= right_avg;
      nearest_q   <= (left_avg < right_avg) ? left_avg : right_avg;
      diff_q      <= diff_t'({1'b0, left_avg} - {1'b0, right_avg});
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.left_average     = left_avg_q;
  assign out_o.right_average    = right_avg_q;
  assign out_o.nearest_distance = nearest_q;
  assign out_o.side_difference  = diff_q;

endmodule

`default_nettype wire

// File: dv/testbench.sv
// self-checking testbench for the dual range moving average unit
`timescale 1ns / 1ps

module testbench;
  import drma_pkg::*;

  localparam int unsigned WINDOW       = 8;
  localparam int unsigned HOLD_CYCLES  = 64;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_LIMIT  = 2000;

  typedef logic [18:0] win_sum_t;

  typedef struct packed {
    sample_t left_average;
    sample_t right_average;
    sample_t nearest_distance;
    diff_t   side_difference;
  } averages_t;

  logic    clk;
  logic    rst_n;
  logic    cfg_we;
  sample_t cfg_wdata;

  drma_in_if  in_bus ();
  drma_out_if out_bus ();

  dual_range_moving_average_unit #(
    .WINDOW (WINDOW)
  ) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  // filter state as the block should hold it
  sample_t     clamp_limit = MAX_DIST_RST;
  sample_t     left_window  [WINDOW] = '{default: '0};
  sample_t     right_window [WINDOW] = '{default: '0};
  win_sum_t    left_total  = '0;
  win_sum_t    right_total = '0;
  int unsigned write_slot  = 0;

  averages_t   expected_averages[$];
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles  = 0;
  bit          idle_en  = 1'b1;
  bit          hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic sample_t clamp_range(range_t raw);
    if (raw >= RANGE_W'(clamp_limit)) return clamp_limit;
    return sample_t'(raw);
  endfunction

  function automatic averages_t predict_averages(range_t lr, bit lto, range_t rr, bit rto);
    averages_t   res;
    sample_t     v;
    int unsigned slot;
    slot = (write_slot < WINDOW) ? write_slot : 0;
    if (!lto) begin
      v = clamp_range(lr);
      left_total = left_total - left_window[slot] + v;
      left_window[slot] = v;
    end
    if (!rto) begin
      v = clamp_range(rr);
      right_total = right_total - right_window[slot] + v;
      right_window[slot] = v;
    end
    write_slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
    res.left_average     = sample_t'(left_total / WINDOW);
    res.right_average    = sample_t'(right_total / WINDOW);
    res.nearest_distance = (res.left_average < res.right_average) ?
                           res.left_average : res.right_average;
    res.side_difference  = diff_t'({1'b0, res.left_average} - {1'b0, res.right_average});
    return res;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    mismatch_cnt++;
  endtask

  // drives one sample pair and waits for its beat to be taken
  task automatic send_pair(range_t lr, bit lto, range_t rr, bit rto);
    int unsigned gap;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_bus.valid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
    end
    in_bus.valid           <= 1'b1;
    in_bus.left_range      <= lr;
    in_bus.left_timed_out  <= lto;
    in_bus.right_range     <= rr;
    in_bus.right_timed_out <= rto;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    expected_averages.push_back(predict_averages(lr, lto, rr, rto));
  endtask

  function automatic range_t pick_range();
    int val;
    case ($urandom_range(0, 3))
      0: val = $urandom_range(0, 65535);
      1: begin
        val = int'(clamp_limit) + int'($urandom_range(0, 4)) - 2;
        if (val < 0) val = 0;
      end
      default: val = $urandom_range(0, clamp_limit);
    endcase
    return range_t'(val);
  endfunction

  task automatic send_random(int unsigned n);
    repeat (n) begin
      send_pair(pick_range(), $urandom_range(0, 3) == 0,
                pick_range(), $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (expected_averages.size() != 0) @(posedge clk);
  endtask

  task automatic set_clamp_limit(sample_t value);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    clamp_limit = value;
  endtask

  task automatic test_directed();
    send_pair(16'd0,     1'b1, 16'd0,     1'b1);
    send_pair(16'd0,     1'b0, 16'd0,     1'b0);
    send_pair(16'd65535, 1'b0, 16'd65535, 1'b0);
    send_pair(16'd2000,  1'b0, 16'd1999,  1'b0);
    send_pair(16'd2001,  1'b0, 16'd8191,  1'b0);
    send_pair(16'd1,     1'b0, 16'd65534, 1'b1);
    send_pair(16'd777,   1'b1, 16'd1234,  1'b0);
    send_pair(16'd0,     1'b0, 16'd2000,  1'b0);
    // full window one way then the other, covering wrap and both signs
    repeat (WINDOW) send_pair(16'd65535, 1'b0, 16'd0, 1'b0);
    repeat (WINDOW) send_pair(16'd0, 1'b0, 16'd65535, 1'b0);
  endtask

  task automatic test_limit_extremes();
    set_clamp_limit(sample_t'(8191));
    repeat (WINDOW) send_pair(range_t'($urandom_range(8191, 65535)), 1'b0, 16'd0, 1'b0);
    repeat (WINDOW) send_pair(16'd0, 1'b0, range_t'($urandom_range(8191, 65535)), 1'b0);
    // stored samples survive a limit change
    set_clamp_limit(sample_t'(0));
    send_pair(16'd65535, 1'b1, 16'd65535, 1'b1);
    send_random(WINDOW + 2);
    set_clamp_limit(sample_t'(1));
    send_random(20);
  endtask

  task automatic test_random_limits();
    send_random(200);
    set_clamp_limit(sample_t'($urandom_range(2, 8190)));
    send_random(250);
    set_clamp_limit(sample_t'(8191));
    send_random(250);
    set_clamp_limit(MAX_DIST_RST);
    send_random(250);
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    send_random(40);
    drain_results();
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      send_random(30);
      drain_results();
    end
  endtask

  task automatic test_steady_stream();
    idle_en = 1'b0;
    set_clamp_limit(sample_t'($urandom_range(0, 8191)));
    send_random(300);
  endtask

  // result sink with random stalls and one long hold on request
  initial begin
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    averages_t want;
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (expected_averages.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = expected_averages.pop_front();
        if (out_bus.left_average !== want.left_average)
          report_mismatch("left_average", out_bus.left_average, want.left_average);
        if (out_bus.right_average !== want.right_average)
          report_mismatch("right_average", out_bus.right_average, want.right_average);
        if (out_bus.nearest_distance !== want.nearest_distance)
          report_mismatch("nearest_distance", out_bus.nearest_distance,
                          want.nearest_distance);
        if (out_bus.side_difference !== want.side_difference)
          report_mismatch("side_difference", int'(out_bus.side_difference),
                          int'(want.side_difference));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
          (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_wdata              = '0;
    in_bus.valid           = 1'b0;
    in_bus.left_range      = '0;
    in_bus.left_timed_out  = 1'b0;
    in_bus.right_range     = '0;
    in_bus.right_timed_out = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_limit_extremes();
    test_random_limits();
    test_backpressure();
    test_drain_pause();
    test_steady_stream();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && expected_averages.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
